@@ hw/rtl/fixed_priority_task_scheduler_unit_assert.svh @@
// Assertion macros for the fixed-priority task scheduler.
// Used by files that assert; clk and rst_n must be in scope where used.
`ifndef FIXED_PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define FIXED_PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every edge outside reset.
`define FPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FPTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPTS_ASSERT(lbl, prop, msg)
`define FPTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/fpts_pkg.sv @@
// Shared types and constants of the fixed-priority task scheduler.
// No dependencies; used by the interfaces, the task cell and the top level.
package fpts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int OP_W      = 3;
  localparam int KEY_W     = 16;
  localparam int PRI_W     = 7;
  localparam int STAT_W    = 2;
  localparam int RUN_W     = 4;

  localparam logic [RUN_W-1:0] RUN_NONE = RUN_W'(MAX_TASKS);

  // Result status codes.
  localparam logic [STAT_W-1:0] RS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] RS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] RS_NOKEY = 2'd2;

  // Operation codes; the two remaining codes do nothing.
  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_ACT     = 3'd1,
    OP_ACT_ISR = 3'd2,
    OP_TERM    = 3'd3,
    OP_CHAIN   = 3'd4,
    OP_SCHED   = 3'd5
  } fpts_op_t;

  // Per-task state.
  typedef enum logic [1:0] {
    TS_IDLE    = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2
  } fpts_task_st_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic             act;
    logic             found;
    logic             best_vld;
    logic [IDX_W-1:0] best_idx;
    logic [PRI_W-1:0] best_pri;
  } fpts_tok_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             rel_en;
    fpts_task_st_t    rel_state;
    logic             lookup;
    logic             pick;
    logic             add_en;
    logic             run_en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic             autostart;
  } fpts_cmd_t;

endpackage

@@ hw/rtl/fpts_if.sv @@
// Valid/ready channel interfaces for the task scheduler's input and result items.
// Depends on fpts_pkg for the field widths.
interface fpts_in_if import fpts_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] task_key;
  logic [PRI_W-1:0] priority_req;
  logic             autostart;

  modport source (output valid, operation, task_key, priority_req, autostart, input ready);
  modport sink   (input valid, operation, task_key, priority_req, autostart, output ready);
endinterface

interface fpts_out_if import fpts_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              dispatched;
  logic [RUN_W-1:0]  running_task;

  modport source (output valid, status, dispatched, running_task, input ready);
  modport sink   (input valid, status, dispatched, running_task, output ready);
endinterface

@@ hw/rtl/fixed_priority_task_scheduler_unit.sv @@
// Fixed-priority task scheduler: task table as a chain of cells plus controller.
// Depends on fpts_pkg, fpts_if, fpts_cell and the assertion macro header.
//
// Usage: each item on in_if carries an operation (add, activate, activate from
// interrupt, terminate, chain, schedule), a task key, a priority and an autostart
// flag. Exactly one result item per input item appears on out_if, in order: a
// status code, a dispatched flag and the index of the running task (eight means
// none). Both channels use valid/ready; an item moves when both are high.
// Add and the unused codes pass from acceptance through a prep and a commit step
// to the result register; operations that search the table also wait in a sweep
// step for the token that walks the cell chain one cell per cycle.
// One item is in work at a time; in_if.ready is high only while the controller
// is idle, so a new item is taken only once the last one has committed. The
// result register is separate, so a new item is accepted while a result still
// waits; the next item then holds in its commit step until the receiver takes
// the waiting result.
// Reset (synchronous, active low) empties the table, marks every task idle and
// sets the running index to none; no clearing pass is needed.
`include "fixed_priority_task_scheduler_unit_assert.svh"

module fixed_priority_task_scheduler_unit import fpts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  fpts_in_if.sink      in_if,
  fpts_out_if.source   out_if
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_COMMIT = 4'b1000
  } fpts_state_t;

  fpts_state_t       state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [PRI_W-1:0]  pri_r;
  logic              auto_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RUN_W-1:0]  running_r, running_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [STAT_W-1:0] out_stat_r;
  logic              out_disp_r;
  logic [RUN_W-1:0]  out_run_r;

  logic              in_acc;
  logic              full;
  logic              is_add, is_lookup, is_pick, is_rel;
  fpts_task_st_t     rel_state;
  logic              commit_go;
  logic              disp;
  logic [RUN_W-1:0]  run_fin;
  fpts_cmd_t         cmd;
  fpts_tok_t         tok [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] run_vec;

  assign in_acc    = in_if.valid && in_if.ready;
  assign full      = (count_r >= CNT_W'(MAX_TASKS));
  assign commit_go = (state_r == ST_COMMIT) && (!out_vld_r || out_if.ready);

  // Operation decode.
  always_comb begin
    is_add    = 1'b0;
    is_lookup = 1'b0;
    is_pick   = 1'b0;
    is_rel    = 1'b0;
    rel_state = TS_READY;
    case (fpts_op_t'(op_r))
      OP_ADD: begin
        is_add = 1'b1;
      end
      OP_ACT: begin
        is_rel    = 1'b1;
        is_lookup = 1'b1;
        is_pick   = 1'b1;
      end
      OP_ACT_ISR: begin
        is_rel    = 1'b1;
        is_lookup = 1'b1;
      end
      OP_TERM: begin
        is_rel    = 1'b1;
        rel_state = TS_IDLE;
        is_pick   = 1'b1;
      end
      OP_CHAIN: begin
        is_rel    = 1'b1;
        rel_state = TS_IDLE;
        is_lookup = 1'b1;
        is_pick   = 1'b1;
      end
      OP_SCHED: begin
        is_rel  = 1'b1;
        is_pick = 1'b1;
      end
      default: begin
        is_add = 1'b0;
      end
    endcase
  end

  // Command broadcast to the cells.
  always_comb begin
    cmd           = '0;
    cmd.rel_en    = (state_r == ST_PREP) && is_rel;
    cmd.rel_state = rel_state;
    cmd.lookup    = is_lookup;
    cmd.pick      = is_pick;
    cmd.add_en    = (state_r == ST_PREP) && is_add && !full;
    cmd.run_en    = commit_go && is_pick && best_vld_r;
    cmd.idx       = (state_r == ST_COMMIT) ? best_idx_r : count_r[IDX_W-1:0];
    cmd.key       = key_r;
    cmd.pri       = pri_r;
    cmd.autostart = auto_r;
  end

  // The token enters the first cell together with the release.
  always_comb begin
    tok[0]     = '0;
    tok[0].act = (state_r == ST_PREP) && (is_lookup || is_pick);
  end

  // Cell chain.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    fpts_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx_i (IDX_W'(i)),
      .cmd_i (cmd),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .run_o (run_vec[i])
    );
  end

  assign disp    = is_pick && best_vld_r;
  assign run_fin = disp ? {{(RUN_W-IDX_W){1'b0}}, best_idx_r} : running_r;

  // Controller next state.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    running_nxt  = running_r;
    stat_nxt     = stat_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        stat_nxt = (is_add && full) ? RS_FULL : RS_OK;
        if (is_add && !full) begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (is_rel) begin
          running_nxt = RUN_NONE;
        end
        state_nxt = (is_lookup || is_pick) ? ST_SWEEP : ST_COMMIT;
      end
      ST_SWEEP: begin
        if (tok[MAX_TASKS].act) begin
          best_vld_nxt = tok[MAX_TASKS].best_vld;
          best_idx_nxt = tok[MAX_TASKS].best_idx;
          if (is_lookup && !tok[MAX_TASKS].found) begin
            stat_nxt = RS_NOKEY;
          end
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          running_nxt = run_fin;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      running_r  <= RUN_NONE;
      out_vld_r  <= 1'b0;
      stat_r     <= RS_OK;
      best_vld_r <= 1'b0;
      best_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      running_r  <= running_nxt;
      out_vld_r  <= out_vld_nxt;
      stat_r     <= stat_nxt;
      best_vld_r <= best_vld_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_if.operation;
      key_r  <= in_if.task_key;
      pri_r  <= in_if.priority_req;
      auto_r <= in_if.autostart;
    end
    if (commit_go) begin
      out_stat_r <= stat_r;
      out_disp_r <= disp;
      out_run_r  <= run_fin;
    end
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_vld_r;
  assign out_if.status       = out_stat_r;
  assign out_if.dispatched   = out_disp_r;
  assign out_if.running_task = out_run_r;

  // Checks on the table and the controller.
  `FPTS_ASSERT(a_one_running, $countones(run_vec) <= 1, "more than one task running")
  `FPTS_ASSERT(a_run_idx_match, (state_r == ST_IDLE && running_r != RUN_NONE) |-> run_vec[running_r[IDX_W-1:0]], "running index does not point at a running task")
  `FPTS_ASSERT(a_none_running, (state_r == ST_IDLE && running_r == RUN_NONE) |-> (run_vec == '0), "task running while index says none")
  `FPTS_ASSERT(a_count_range, count_r <= CNT_W'(MAX_TASKS), "task count beyond table size")
  `FPTS_ASSERT(a_sweep_end, (state_r == ST_SWEEP && tok[MAX_TASKS].act) |=> (state_r == ST_COMMIT), "token left the chain without a commit")

endmodule

@@ hw/rtl/fpts_cell.sv @@
// One task table entry: key, priority, state, and one stage of the search chain.
// Depends on fpts_pkg.
module fpts_cell import fpts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx_i,
  input  fpts_cmd_t        cmd_i,
  input  fpts_tok_t        tok_i,
  output fpts_tok_t        tok_o,
  output logic             run_o
);

  fpts_task_st_t    status_r, status_nxt;
  logic             occ_r, occ_nxt;
  logic [KEY_W-1:0] key_r;
  logic [PRI_W-1:0] pri_r;
  fpts_tok_t        tok_r, tok_nxt;

  logic             sel;
  logic             match;
  logic             cand;
  fpts_task_st_t    st_eff;
  fpts_task_st_t    st_pick;

  // Entry update and token processing.
  always_comb begin
    sel = (cmd_i.idx == idx_i);
    // A release in the same cycle as the token is folded in first.
    st_eff = (cmd_i.rel_en && status_r == TS_RUNNING) ? cmd_i.rel_state : status_r;
    match  = tok_i.act && cmd_i.lookup && !tok_i.found && occ_r && (key_r == cmd_i.key);
    st_pick = match ? TS_READY : st_eff;
    cand = tok_i.act && cmd_i.pick && occ_r && (st_pick == TS_READY) &&
           (pri_r >= tok_i.best_pri);

    status_nxt = st_pick;
    occ_nxt    = occ_r;
    if (cmd_i.add_en && sel) begin
      status_nxt = cmd_i.autostart ? TS_READY : TS_IDLE;
      occ_nxt    = 1'b1;
    end
    if (cmd_i.run_en && sel) begin
      status_nxt = TS_RUNNING;
    end

    tok_nxt       = tok_i;
    tok_nxt.found = tok_i.found | match;
    if (cand) begin
      tok_nxt.best_vld = 1'b1;
      tok_nxt.best_idx = idx_i;
      tok_nxt.best_pri = pri_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= TS_IDLE;
      occ_r    <= 1'b0;
      tok_r    <= '0;
    end else begin
      status_r <= status_nxt;
      occ_r    <= occ_nxt;
      tok_r    <= tok_nxt;
    end
  end

  // Entry payload, written on add.
  always_ff @(posedge clk) begin
    if (cmd_i.add_en && sel) begin
      key_r <= cmd_i.key;
      pri_r <= cmd_i.pri;
    end
  end

  assign tok_o = tok_r;
  assign run_o = (status_r == TS_RUNNING);

endmodule
